// ----- sv/brms_pkg.sv -----
// ============================================================================
// brms_pkg - shared types and constants for the register machine step block
// Opcodes, instruction sizes and costs, and the decoded word that passes
// from the decode front end through the queue to the execute back end.
// ============================================================================
package brms_pkg;

    // Field widths
    localparam int DATA_W      = 32;
    localparam int REG_COUNT   = 16;
    localparam int REG_IDX_W   = 4;
    localparam int OFFSET_W    = 8;
    localparam int DELTA_W     = 10;
    localparam int PC_MAX_W    = 16;
    localparam int NEXT_PC_W   = 12;
    localparam int TALLY_W     = 32;
    localparam int COST_W      = 3;
    localparam int OP_W        = 3;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 80;

    // Program size default and decode queue depth (power of two)
    localparam int DEF_PROGRAM_BYTES = 4096;
    localparam int QUEUE_DEPTH       = 4;

    // Instruction sizes in bytes
    localparam int SIZE_RET   = 1;
    localparam int SIZE_SHORT = 2;
    localparam int SIZE_MOVI  = 6;

    // Instruction costs in machine cycles
    localparam logic [COST_W-1:0] COST_RET   = 3'd1;
    localparam logic [COST_W-1:0] COST_SHORT = 3'd2;
    localparam logic [COST_W-1:0] COST_MOVI  = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_RET   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SUB   = 3'd2,
        OP_MOV   = 3'd3,
        OP_MOVI  = 3'd4,
        OP_BR    = 3'd5,
        OP_BNZ   = 3'd6,
        OP_START = 3'd7
    } op_t;

    // Decoded instruction word; delta is the taken pc step, already reduced
    // modulo the program size
    typedef struct packed {
        op_t                   op;
        logic [REG_IDX_W-1:0]  dst;
        logic [REG_IDX_W-1:0]  src;
        logic [DATA_W-1:0]     imm;
        logic [PC_MAX_W-1:0]   delta;
        logic [COST_W-1:0]     cost;
        logic                  wr_reg;
        logic                  set_flags;
    } brms_item_t;

endpackage

// ----- sv/brms_front.sv -----
// ============================================================================
// brms_front - instruction decode front end
// Accepts input words, classifies the operation, reduces the pc step modulo
// the program size and hands the decoded word to the queue.
// ============================================================================
module brms_front import brms_pkg::*; #(
    parameter int PROGRAM_BYTES = DEF_PROGRAM_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // reg_pair[7:0], immediate[39:8], offset[47:40]
    input  logic [OP_W-1:0]       s_tuser,   // operation[2:0]
    output logic                  push_valid,
    input  logic                  push_ready,
    output brms_item_t            push_item
);

    localparam int PC_W     = $clog2(PROGRAM_BYTES);
    localparam int RW       = PC_W + 6;
    localparam int RED_BIAS = PROGRAM_BYTES * ((128 + PROGRAM_BYTES - 1) / PROGRAM_BYTES);
    localparam logic [RW-1:0] MOD_P = RW'(PROGRAM_BYTES);

    logic                     valid_reg;
    brms_item_t               item_reg;
    brms_item_t               item_next;
    op_t                      op;
    logic [REG_IDX_W*2-1:0]   reg_pair;
    logic signed [OFFSET_W-1:0] offset;
    logic signed [DELTA_W-1:0]  delta_raw;
    logic [RW-1:0]            red;

    assign op       = op_t'(s_tuser);
    assign reg_pair = s_tdata[7:0];
    assign offset   = s_tdata[47:40];

    // Classify the operation: pc step, cost and side effects
    always_comb begin
        item_next           = '0;
        item_next.op        = op;
        item_next.dst       = reg_pair[7:4];
        item_next.src       = reg_pair[3:0];
        item_next.imm       = s_tdata[39:8];
        delta_raw           = '0;
        unique case (op)
            OP_RET: begin
                delta_raw      = DELTA_W'(SIZE_RET);
                item_next.cost = COST_RET;
            end
            OP_ADD, OP_SUB: begin
                delta_raw           = DELTA_W'(SIZE_SHORT);
                item_next.cost      = COST_SHORT;
                item_next.wr_reg    = 1'b1;
                item_next.set_flags = 1'b1;
            end
            OP_MOV: begin
                delta_raw        = DELTA_W'(SIZE_SHORT);
                item_next.cost   = COST_SHORT;
                item_next.wr_reg = 1'b1;
            end
            OP_MOVI: begin
                delta_raw        = DELTA_W'(SIZE_MOVI);
                item_next.cost   = COST_MOVI;
                item_next.wr_reg = 1'b1;
            end
            OP_BR, OP_BNZ: begin
                delta_raw      = DELTA_W'(offset) + DELTA_W'(SIZE_SHORT);
                item_next.cost = COST_SHORT;
            end
            default: begin
                delta_raw      = '0;
                item_next.cost = '0;
            end
        endcase

        // Reduce the step into [0, PROGRAM_BYTES) by restoring subtraction
        red = RW'(delta_raw) + RW'(RED_BIAS);
        for (int k = 4; k >= 0; k--) begin
            if (red >= (MOD_P << k)) begin
                red = red - (MOD_P << k);
            end
        end
        item_next.delta = PC_MAX_W'(red);
    end

    // Hold one decoded word until the queue takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

endmodule

// ----- sv/brms_fifo.sv -----
// ============================================================================
// brms_fifo - decoded instruction queue
// Small first-in first-out buffer that lets decode and execute stall apart.
// ============================================================================
module brms_fifo import brms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  brms_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output brms_item_t out_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    brms_item_t       store_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = store_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- sv/brms_exec.sv -----
// ============================================================================
// brms_exec - execute back end
// Reads the register file, executes one instruction per cycle unless m_tready
// stalls, with a one-deep bypass, updates machine state, registers the result.
// ============================================================================
module brms_exec import brms_pkg::*; #(
    parameter int PROGRAM_BYTES = DEF_PROGRAM_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  brms_item_t             q_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PC_W = $clog2(PROGRAM_BYTES);

    // Register file storage and read stage
    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] vbits_reg;
    logic                 s1_valid_reg;
    brms_item_t           s1_item_reg;
    logic [DATA_W-1:0]    rd_dst_reg;
    logic [DATA_W-1:0]    rd_src_reg;

    // Bypass record of the last executed word
    logic                 last_start_reg;
    logic                 last_wr_reg;
    logic [REG_IDX_W-1:0] last_addr_reg;
    logic [DATA_W-1:0]    last_data_reg;

    // Machine state
    logic [PC_W-1:0]      pc_reg,    pc_next;
    logic                 zf_reg,    zf_next;
    logic                 nf_reg,    nf_next;
    logic [TALLY_W-1:0]   tally_reg, tally_next;
    logic                 halt_reg,  halt_next;
    logic [DATA_W-1:0]    reg0_reg,  reg0_next;

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    logic                 exec_fire;
    logic                 load;
    logic                 is_start;
    logic [DATA_W-1:0]    opa;
    logic [DATA_W-1:0]    opb;
    logic [DATA_W-1:0]    alu;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] wr_addr;
    logic [DATA_W-1:0]    wr_data;
    logic [PC_W-1:0]      step;
    logic [PC_W:0]        pc_sum;
    logic [PC_W+NEXT_PC_W-1:0] pc_wide;

    assign exec_fire = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign q_ready   = !s1_valid_reg || exec_fire;
    assign load      = q_valid && q_ready;
    assign is_start  = (s1_item_reg.op == OP_START);

    // Bypass the write of the last executed word
    always_comb begin
        opa = rd_dst_reg;
        opb = rd_src_reg;
        if (last_start_reg) begin
            opa = (s1_item_reg.dst == '0) ? last_data_reg : '0;
            opb = (s1_item_reg.src == '0) ? last_data_reg : '0;
        end else if (last_wr_reg) begin
            if (last_addr_reg == s1_item_reg.dst) begin
                opa = last_data_reg;
            end
            if (last_addr_reg == s1_item_reg.src) begin
                opb = last_data_reg;
            end
        end
    end

    // Arithmetic and move data
    always_comb begin
        unique case (s1_item_reg.op)
            OP_ADD:  alu = opa + opb;
            OP_SUB:  alu = opa - opb;
            OP_MOV:  alu = opb;
            OP_MOVI: alu = s1_item_reg.imm;
            default: alu = opa;
        endcase
    end

    // Register file write port
    assign wr_en   = exec_fire && (is_start || (!halt_reg && s1_item_reg.wr_reg));
    assign wr_addr = is_start ? '0 : s1_item_reg.dst;
    assign wr_data = is_start ? s1_item_reg.imm : alu;

    // Next pc: taken or fall-through step, wrapped once at the program size
    always_comb begin
        if (s1_item_reg.op == OP_BNZ && zf_reg) begin
            step = PC_W'(SIZE_SHORT);
        end else begin
            step = s1_item_reg.delta[PC_W-1:0];
        end
        pc_sum = {1'b0, pc_reg} + {1'b0, step};
        if (pc_sum >= (PC_W+1)'(PROGRAM_BYTES)) begin
            pc_sum = pc_sum - (PC_W+1)'(PROGRAM_BYTES);
        end
    end

    // Next machine state
    always_comb begin
        pc_next    = pc_reg;
        zf_next    = zf_reg;
        nf_next    = nf_reg;
        tally_next = tally_reg;
        halt_next  = halt_reg;
        reg0_next  = reg0_reg;
        if (is_start) begin
            pc_next    = '0;
            zf_next    = 1'b0;
            nf_next    = 1'b0;
            tally_next = '0;
            halt_next  = 1'b0;
            reg0_next  = s1_item_reg.imm;
        end else if (!halt_reg) begin
            pc_next    = pc_sum[PC_W-1:0];
            tally_next = tally_reg + TALLY_W'(s1_item_reg.cost);
            if (s1_item_reg.op == OP_RET) begin
                halt_next = 1'b1;
            end
            if (s1_item_reg.set_flags) begin
                zf_next = (alu == '0);
                nf_next = alu[DATA_W-1];
            end
            if (s1_item_reg.wr_reg && s1_item_reg.dst == '0) begin
                reg0_next = alu;
            end
        end
    end

    assign pc_wide = {{NEXT_PC_W{1'b0}}, pc_next};

    // Memory write and registered reads into the read stage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (load) begin
            rd_dst_reg  <= vbits_reg[q_item.dst] ? mem[q_item.dst] : '0;
            rd_src_reg  <= vbits_reg[q_item.src] ? mem[q_item.src] : '0;
            s1_item_reg <= q_item;
        end
    end

    // Control state, bypass record and machine state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vbits_reg      <= '0;
            s1_valid_reg   <= 1'b0;
            last_start_reg <= 1'b0;
            last_wr_reg    <= 1'b0;
            pc_reg         <= '0;
            zf_reg         <= 1'b0;
            nf_reg         <= 1'b0;
            tally_reg      <= '0;
            halt_reg       <= 1'b0;
            reg0_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (load) begin
                s1_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (exec_fire && is_start) begin
                vbits_reg <= REG_COUNT'(1);
            end else if (wr_en) begin
                vbits_reg[wr_addr] <= 1'b1;
            end
            if (exec_fire) begin
                last_start_reg <= is_start;
                last_wr_reg    <= wr_en;
                pc_reg         <= pc_next;
                zf_reg         <= zf_next;
                nf_reg         <= nf_next;
                tally_reg      <= tally_next;
                halt_reg       <= halt_next;
                reg0_reg       <= reg0_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Bypass payload and result word
    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            last_addr_reg <= wr_addr;
            last_data_reg <= wr_data;
            m_tdata_reg   <= {1'b0, nf_next, zf_next, tally_next, reg0_next, halt_next,
                              pc_wide[NEXT_PC_W-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Start clears the machine and loads register 0
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && is_start |=> pc_reg == '0 && tally_reg == '0 && !halt_reg
            && reg0_reg == $past(s1_item_reg.imm))
        else $error("start did not clear machine state");

    // A halted machine ignores everything but start
    a_halt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && halt_reg && !is_start |=> $stable(pc_reg) && $stable(tally_reg)
            && $stable(reg0_reg) && halt_reg)
        else $error("halted machine changed state");

    // Tally grows by the instruction cost
    a_tally_step: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire && !halt_reg && !is_start
            |=> tally_reg == $past(tally_reg) + TALLY_W'($past(s1_item_reg.cost)))
        else $error("cycle tally step mismatch");

endmodule

// ----- sv/bytecode_register_machine_step.sv -----
// ============================================================================
// bytecode_register_machine_step - one instruction step of a register machine
// Executes one pre-decoded instruction per input word and reports the state.
// ============================================================================
// Input channel (s_): one instruction per word; operation travels in s_tuser,
//   register pair, immediate and branch offset in s_tdata.
// Output channel (m_): exactly one result word per instruction, in order:
//   next pc, halt mark, register 0, cycle tally, zero and negative flags.
// Path: a result word is offered once its instruction word has passed the
//   decode register, queue, register file read and execute in turn.
// Throughput: one instruction per cycle while m_tready is high, set by the
//   single execute stage, which reads the register file in the stage ahead
//   and bypasses the write of the instruction just before it.
// Reset: aresetn low on a rising edge marks the register file empty so it reads
//   as zero, clears pc, flags, cycle tally and halt mark, and empties the
//   pipeline; s_tready is already high while reset holds.
// Stall: while m_tready is low the result register holds its word; the
//   execute stage, queue and decode register fill in turn before s_tready
//   drops.
// ============================================================================
module bytecode_register_machine_step import brms_pkg::*; #(
    parameter int PROGRAM_BYTES = DEF_PROGRAM_BYTES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // reg_pair[7:0], immediate[39:8], offset[47:40]
    input  logic [OP_W-1:0]        s_tuser,   // operation[2:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // next_pc[11:0], halted[12], result_value[44:13], cycles_used[76:45],
    // zero_out[77], negative_out[78], zero pad[79]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic       push_valid;
    logic       push_ready;
    brms_item_t push_item;
    logic       q_valid;
    logic       q_ready;
    brms_item_t q_item;

    // Decode front end
    brms_front #(
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between decode and execute
    brms_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // Execute back end
    brms_exec #(
        .PROGRAM_BYTES (PROGRAM_BYTES)
    ) u_exec (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
